// ----- rtl/lldp_frame_peer_mac_extractor_defines.svh -----
// Assertion macros for the LLDP peer MAC extractor.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef LLDP_FRAME_PEER_MAC_EXTRACTOR_DEFINES_SVH
`define LLDP_FRAME_PEER_MAC_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LLDPPME_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define LLDPPME_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/lldppme_pkg.sv -----
// Shared types and constants for the LLDP peer MAC extractor.
// No dependencies.
`default_nettype none
package lldppme_pkg;

    localparam int MAX_FRAME_BYTES = 2048;
    // wide enough to hold MAX_FRAME_BYTES itself
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int MAC_W           = 48;
    localparam int OUT_TDATA_W     = 56;

    typedef struct packed {
        logic       last_byte;
        logic [7:0] frame_byte;
    } t_item;

    // is_lldp in the lowest bit
    typedef struct packed {
        logic [MAC_W-1:0] peer_addr;
        logic             peer_valid;
        logic             forward_blocked;
        logic             is_lldp;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/lldppme_in_reg.sv -----
// Input register stage for the LLDP peer MAC extractor.
// Depends on lldppme_pkg.
`default_nettype none
module lldppme_in_reg (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  lldppme_pkg::t_item  i_item,
    input  wire                 i_consume,
    output logic                o_valid,
    output lldppme_pkg::t_item  o_item
);
    import lldppme_pkg::*;

    logic  r_valid;
    t_item r_item;

    // refill in the same cycle the held item is consumed
    assign o_ready = !r_valid || i_consume;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lldppme_parser.sv -----
// Per-byte frame parser: address/ethertype checks, TLV walk, peer latch.
// Depends on lldppme_pkg.
`default_nettype none
module lldppme_parser (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_step,
    input  lldppme_pkg::t_item    i_item,
    output lldppme_pkg::t_result  o_result
);
    import lldppme_pkg::*;

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LEN,
        PH_BODY
    } t_phase;

    localparam logic [7:0] LLDP_DEST [6] = '{8'h01, 8'h80, 8'hC2, 8'h00, 8'h00, 8'h0E};
    localparam logic [7:0] ETYPE_HI      = 8'h88;
    localparam logic [7:0] ETYPE_LO      = 8'hCC;
    localparam logic [6:0] TLV_END       = 7'd0;
    localparam logic [6:0] TLV_CHASSIS   = 7'd1;
    localparam logic [7:0] SUBTYPE_MAC   = 8'd4;
    localparam logic [8:0] MAC_BODY_LEN  = 9'd7;

    logic [CNT_W-1:0] r_count,    n_count;
    logic [MAC_W-1:0] r_src,      n_src;
    logic             r_dst_ok,   n_dst_ok;
    logic             r_etype_ok, n_etype_ok;
    t_phase           r_phase,    n_phase;
    logic [6:0]       r_kind,     n_kind;
    logic [8:0]       r_len,      n_len;
    logic [8:0]       r_body,     n_body;
    logic             r_chassis,  n_chassis;
    logic [MAC_W-1:0] r_peer,     n_peer;
    logic             r_known,    n_known;

    logic [7:0]       b;
    logic [2:0]       src_idx;
    logic [7:0]       src_byte;
    logic             long_enough;

    assign b        = i_item.frame_byte;
    assign src_idx  = 3'd6 - r_body[2:0];
    assign src_byte = r_src[{src_idx, 3'b000} +: 8];

    always_comb begin
        n_count    = r_count;
        n_src      = r_src;
        n_dst_ok   = r_dst_ok;
        n_etype_ok = r_etype_ok;
        n_phase    = r_phase;
        n_kind     = r_kind;
        n_len      = r_len;
        n_body     = r_body;
        n_chassis  = r_chassis;
        n_peer     = r_peer;
        n_known    = r_known;

        // drop bytes beyond the maximum frame size
        if (r_count < CNT_W'(MAX_FRAME_BYTES)) begin
            n_count = r_count + CNT_W'(1);
            if (r_count < CNT_W'(6)) begin
                if (b != LLDP_DEST[r_count[2:0]]) n_dst_ok = 1'b0;
            end else if (r_count < CNT_W'(12)) begin
                n_src = {r_src[MAC_W-9:0], b};
            end else if (r_count == CNT_W'(12)) begin
                if (b != ETYPE_HI) n_etype_ok = 1'b0;
            end else if (r_count == CNT_W'(13)) begin
                if (b != ETYPE_LO) n_etype_ok = 1'b0;
            end else begin
                unique case (r_phase)
                    PH_TYPE: begin
                        n_kind  = b[7:1];
                        n_len   = {b[0], 8'h00};
                        n_phase = PH_LEN;
                    end
                    PH_LEN: begin
                        n_len  = {r_len[8], b};
                        n_body = 9'd0;
                        if (r_kind == TLV_END || n_len == 9'd0) begin
                            n_phase = PH_TYPE;
                        end else begin
                            n_chassis = (r_kind == TLV_CHASSIS);
                            n_phase   = PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        if (r_body == 9'd0) begin
                            if (b != SUBTYPE_MAC) n_chassis = 1'b0;
                        end else if (r_body <= 9'd6) begin
                            if (src_byte != b) n_chassis = 1'b0;
                        end
                        n_body = r_body + 9'd1;
                        if (n_body >= r_len) begin
                            if (r_kind == TLV_CHASSIS && n_chassis &&
                                r_len >= MAC_BODY_LEN && r_dst_ok && r_etype_ok) begin
                                n_peer  = r_src;
                                n_known = 1'b1;
                            end
                            n_phase = PH_TYPE;
                        end
                    end
                    default: n_phase = PH_TYPE;
                endcase
            end
        end

        long_enough              = n_count >= CNT_W'(16);
        o_result.forward_blocked = long_enough && n_etype_ok;
        o_result.is_lldp         = long_enough && n_etype_ok && n_dst_ok;
        o_result.peer_valid      = n_known;
        o_result.peer_addr       = n_peer;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_byte)) begin
            // restart per-frame state; peer survives frame ends
            r_count    <= '0;
            r_src      <= '0;
            r_dst_ok   <= 1'b1;
            r_etype_ok <= 1'b1;
            r_phase    <= PH_TYPE;
            r_kind     <= '0;
            r_len      <= '0;
            r_body     <= '0;
            r_chassis  <= 1'b0;
        end else if (i_step) begin
            r_count    <= n_count;
            r_src      <= n_src;
            r_dst_ok   <= n_dst_ok;
            r_etype_ok <= n_etype_ok;
            r_phase    <= n_phase;
            r_kind     <= n_kind;
            r_len      <= n_len;
            r_body     <= n_body;
            r_chassis  <= n_chassis;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peer  <= '0;
            r_known <= 1'b0;
        end else if (i_step) begin
            r_peer  <= n_peer;
            r_known <= n_known;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lldppme_out_reg.sv -----
// Result register for the LLDP peer MAC extractor.
// Depends on lldppme_pkg.
`default_nettype none
module lldppme_out_reg (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_load,
    input  lldppme_pkg::t_result  i_result,
    output logic                  o_free,
    output logic                  o_valid,
    input  wire                   i_ready,
    output lldppme_pkg::t_result  o_result
);
    import lldppme_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lldp_frame_peer_mac_extractor.sv -----
// LLDP peer MAC extractor. Frame bytes enter on the slave stream, one
// transaction per byte, destination address first, tlast on the final byte.
// Each byte passes an input register and then updates the parser state; a byte
// is taken every cycle but for pauses. One result transaction leaves on the
// master stream per frame, valid once its last byte has passed the input and
// result registers, or later while the previous result still waits. Intake
// pauses only when a last byte is held while the previous result is not taken.
// Depends on lldppme_pkg, lldppme_in_reg, lldppme_parser, lldppme_out_reg and
// lldp_frame_peer_mac_extractor_defines.svh.
`default_nettype none
`include "lldp_frame_peer_mac_extractor_defines.svh"
module lldp_frame_peer_mac_extractor (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // [7:0] frame_byte
    input  wire         i_s_tlast,   // last_byte
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // [0] is_lldp, [1] forward_blocked, [2] peer_valid, [50:3] peer_addr, rest zero
    output logic [55:0] o_m_tdata
);
    import lldppme_pkg::*;

    t_item   in_item, held_item;
    logic    held_valid;
    logic    step;
    logic    out_free;
    t_result parse_result, out_result;
    logic    m_lldp;
    logic    m_no_peer;
    logic    m_stuck;
    logic    m_peer_take;
    logic    m_peer_seen;

    assign in_item.frame_byte = i_s_tdata;
    assign in_item.last_byte  = i_s_tlast;

    // a last byte waits until the result register can take its result
    assign step = held_valid && (!held_item.last_byte || out_free);

    lldppme_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_item    (in_item),
        .i_consume (step),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    lldppme_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (held_item),
        .o_result (parse_result)
    );

    lldppme_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step && held_item.last_byte),
        .i_result (parse_result),
        .o_free   (out_free),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (out_result)
    );

    assign o_m_tdata = {(OUT_TDATA_W - $bits(t_result))'(0), out_result};

    assign m_lldp      = o_m_tvalid && out_result.is_lldp;
    assign m_no_peer   = o_m_tvalid && !out_result.peer_valid;
    assign m_stuck     = o_m_tvalid && !i_m_tready;
    assign m_peer_take = o_m_tvalid && i_m_tready && out_result.peer_valid;
    assign m_peer_seen = !o_m_tvalid || out_result.peer_valid;

    `LLDPPME_ASSERT_IMP(a_lldp_blk, m_lldp, out_result.forward_blocked, "lldp not blocked")
    `LLDPPME_ASSERT_IMP(a_no_peer_zero, m_no_peer, out_result.peer_addr == '0, "stale peer")
    `LLDPPME_ASSERT_IMP(a_stall_cause, !o_s_tready, m_stuck, "intake stalled")
    `LLDPPME_ASSERT_NXT(a_peer_keep, m_peer_take, m_peer_seen, "peer_valid dropped")

endmodule
`default_nettype wire
